// File: src/fbsa_pkg.sv
package fbsa_pkg;

	localparam int TS_W    = 48;
	localparam int PRICE_W = 32;
	localparam int VOL_W   = 32;
	localparam int VAL_W   = 64;
	localparam int CNT_W   = 32;
	localparam int WCNT_W  = 48;
	localparam int HOP_W   = 32;
	localparam int WF_W    = 11;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// register indexes, decoded from paddr[2]
	localparam logic REG_HOP_MS        = 1'b0;
	localparam logic REG_WINDOW_FRAMES = 1'b1;

	localparam logic [HOP_W-1:0] HOP_RESET = 32'd1000;
	localparam logic [WF_W-1:0]  WF_RESET  = 11'd1024;

	// one ring entry: frame value sum and trade count
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] trades;
	} ring_ent_t;

	// one result item
	typedef struct packed {
		logic [VAL_W-1:0]  mean_value;
		logic [WCNT_W-1:0] window_trades;
		logic [TS_W-1:0]   frame_start_time;
		logic              window_empty;
		logic              gap_truncated;
		logic              last;
	} res_t;

	// configuration state toward the core
	typedef struct packed {
		logic [HOP_W-1:0] hop_ms;
		logic [WF_W-1:0]  window_frames;
		logic             win_wr;
	} cfg_t;

endpackage

// File: src/fbsa_if.sv
interface fbsa_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [fbsa_pkg::TS_W-1:0]            timestamp;
	logic [fbsa_pkg::PRICE_W-1:0]         trade_price;
	logic [fbsa_pkg::VOL_W-1:0]           trade_volume;

	modport source (output valid, timestamp, trade_price, trade_volume, input ready);
	modport sink   (input valid, timestamp, trade_price, trade_volume, output ready);
endinterface

interface fbsa_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [fbsa_pkg::VAL_W-1:0]           mean_value;
	logic [fbsa_pkg::WCNT_W-1:0]          window_trades;
	logic [fbsa_pkg::TS_W-1:0]            frame_start_time;
	logic                                 window_empty;
	logic                                 gap_truncated;
	logic                                 last;

	modport source (output valid, mean_value, window_trades, frame_start_time,
		window_empty, gap_truncated, last, input ready);
	modport sink   (input valid, mean_value, window_trades, frame_start_time,
		window_empty, gap_truncated, last, output ready);
endinterface

// File: src/frame_bucketed_sliding_average.sv
// Channel   Dir  Transfer when          Payload
// in_ch     in   valid && ready         timestamp, trade_price, trade_volume
// out_ch    out  valid && ready         mean, window trades, start, empty, trunc, last
// apb       in   psel&penable&pwrite    hop_ms @0x0, window_frames @0x4
//
// A trade inside the open frame is captured, multiplied and checked. A frame
// close adds the frame-count divide and a final step, then per ring step a
// read, subtract and add, plus a shared-divider divide per reported mean
// (skipped for an empty window); a long gap adds one more divide to rotate the
// ring head. No clearing pass after reset. One result waits in the output
// register and one in a pending register, so the core stalls only when both are full.
module frame_bucketed_sliding_average #(
	parameter int RING_DEPTH      = 1024,
	parameter int MAX_GAP_RESULTS = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fbsa_in_if.sink                     in_ch,
	fbsa_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbsa_pkg::APB_AW-1:0] paddr,
	input  logic [fbsa_pkg::APB_DW-1:0] pwdata,
	output logic [fbsa_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = ((AW > fbsa_pkg::WF_W) ? AW : fbsa_pkg::WF_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_CHECK, S_KDIV, S_PUSH_RD, S_PUSH_SUB, S_PUSH_ADD,
		S_MSTART, S_MDIV, S_RESULT, S_NEXT, S_ADV_DIV, S_FINAL
	} state_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] floor_sub64(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	state_t                        state_q;
	fbsa_pkg::cfg_t                cfg;

	logic [47:0]                   ts_q;
	logic [31:0]                   price_q;
	logic [31:0]                   vol_q;
	logic [63:0]                   value_q;

	logic                          started_q;
	logic [47:0]                   fb_q;
	logic [63:0]                   fv_q;
	logic [31:0]                   fc_q;

	logic [AW-1:0]                 head_q;
	logic [10:0]                   filled_q;
	logic [63:0]                   wv_q;
	logic [47:0]                   wc_q;

	logic [47:0]                   gaps_q;
	logic [11:0]                   walk_q;
	logic [11:0]                   j_q;
	logic [47:0]                   new_fb_q;
	logic [47:0]                   gap_t_q;
	logic                          first_q;
	logic                          slid_q;
	logic [5:0]                    reported_q;
	logic                          trunc_q;

	fbsa_pkg::res_t                new_q;
	fbsa_pkg::res_t                pend_q;
	logic                          pend_v_q;
	fbsa_pkg::res_t                out_q;
	logic                          out_v_q;
	fbsa_pkg::res_t                fin_res;

	// effective window and hop
	logic [10:0]                   w_eff;
	logic [31:0]                   hop_eff;
	logic [CW-1:0]                 w_ext;
	logic [CW-1:0]                 head_ext;
	logic [AW-1:0]                 head_use;
	logic [CW-1:0]                 head_inc;
	logic [CW-1:0]                 head_adv;
	logic [47:0]                   ts_span;
	logic [11:0]                   limit;
	logic [47:0]                   k_m1;
	logic                          out_free;
	logic [64:0]                   wc_sum;
	logic [63:0]                   wc_sub;
	logic [11:0]                   j_inc;

	// divider and ring hookup
	logic                          div_start;
	logic [63:0]                   div_dvd;
	logic [47:0]                   div_dvs;
	logic                          div_done;
	logic [63:0]                   div_quo;
	logic [47:0]                   div_rem;
	fbsa_pkg::ring_ent_t           rd_data;
	fbsa_pkg::ring_ent_t           wr_data;
	logic                          rd_en;
	logic                          wr_en;

	fbsa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbsa_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (head_use),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (head_q),
		.wr_data (wr_data)
	);

	fbsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		if (cfg.window_frames == '0) begin
			w_eff = 11'd1;
		end else if ({21'b0, cfg.window_frames} > 32'(RING_DEPTH)) begin
			w_eff = 11'(RING_DEPTH);
		end else begin
			w_eff = cfg.window_frames;
		end
	end

	assign hop_eff  = (cfg.hop_ms == '0) ? 32'd1 : cfg.hop_ms;
	assign w_ext    = CW'(w_eff);
	assign head_ext = CW'(head_q);
	assign head_use = (head_ext >= w_ext) ? '0 : head_q;
	assign head_inc = head_ext + CW'(1);
	assign head_adv = head_ext + CW'(div_rem[10:0]);
	assign ts_span  = ts_q - fb_q;
	assign limit    = {w_eff, 1'b0} + 12'(MAX_GAP_RESULTS);
	assign k_m1     = div_quo[47:0] - 48'd1;
	assign out_free = !out_v_q || out_ch.ready;
	assign wc_sum   = {17'b0, wc_q} + {33'b0, (first_q ? fc_q : 32'd0)};
	assign wc_sub   = floor_sub64({16'b0, wc_q}, {32'b0, rd_data.trades});
	assign j_inc    = j_q + 12'd1;

	assign rd_en           = (state_q == S_PUSH_RD);
	assign wr_en           = (state_q == S_PUSH_ADD);
	assign wr_data.value   = first_q ? fv_q : '0;
	assign wr_data.trades  = first_q ? fc_q : '0;

	// final result of a trade carries last and the truncation flag
	always_comb begin
		fin_res               = pend_q;
		fin_res.last          = 1'b1;
		fin_res.gap_truncated = trunc_q;
	end

	// divider operands per use: frame count, ring rotation, window mean
	always_comb begin
		div_start = 1'b0;
		div_dvd   = {16'b0, ts_span};
		div_dvs   = {16'b0, hop_eff};
		case (state_q)
			S_CHECK: begin
				div_start = started_q && !(ts_q < fb_q) && !(ts_span < {16'b0, hop_eff});
			end
			S_NEXT: begin
				div_dvd   = {16'b0, gaps_q - {36'b0, walk_q}};
				div_dvs   = {37'b0, w_eff};
				div_start = !(first_q ? (walk_q != '0) : (j_inc < walk_q))
					&& (gaps_q > {36'b0, walk_q});
			end
			S_MSTART: begin
				div_dvd   = wv_q;
				div_dvs   = wc_q;
				div_start = (wc_q != '0);
			end
			default: begin
			end
		endcase
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			started_q  <= 1'b0;
			fb_q       <= '0;
			fv_q       <= '0;
			fc_q       <= '0;
			head_q     <= '0;
			filled_q   <= '0;
			wv_q       <= '0;
			wc_q       <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			first_q    <= 1'b0;
			slid_q     <= 1'b0;
			reported_q <= '0;
			trunc_q    <= 1'b0;
			j_q        <= '0;
			gaps_q     <= '0;
			walk_q     <= '0;
			new_fb_q   <= '0;
			gap_t_q    <= '0;
			new_q      <= '0;
			pend_q     <= '0;
			out_q      <= '0;
		end else begin
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg.win_wr) begin
				head_q   <= '0;
				filled_q <= '0;
				wv_q     <= '0;
				wc_q     <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!started_q) begin
						started_q <= 1'b1;
						fb_q      <= ts_q;
						fv_q      <= value_q;
						fc_q      <= 32'd1;
						state_q   <= S_IDLE;
					end else if (ts_q < fb_q || ts_span < {16'b0, hop_eff}) begin
						fv_q <= sat_add64(fv_q, value_q);
						if (fc_q != '1) begin
							fc_q <= fc_q + 32'd1;
						end
						state_q <= S_IDLE;
					end else begin
						state_q <= S_KDIV;
					end
				end
				S_KDIV: begin
					if (div_done) begin
						gaps_q     <= k_m1;
						walk_q     <= (k_m1 < {36'b0, limit}) ? k_m1[11:0] : limit;
						new_fb_q   <= ts_q - div_rem;
						gap_t_q    <= fb_q + {16'b0, hop_eff};
						first_q    <= 1'b1;
						j_q        <= '0;
						reported_q <= '0;
						trunc_q    <= 1'b0;
						state_q    <= S_PUSH_RD;
					end
				end
				S_PUSH_RD: begin
					head_q  <= head_use;
					state_q <= S_PUSH_SUB;
				end
				S_PUSH_SUB: begin
					// drop the oldest frame once the ring is full
					if ({1'b0, filled_q} >= {1'b0, w_eff}) begin
						wv_q   <= floor_sub64(wv_q, rd_data.value);
						wc_q   <= wc_sub[47:0];
						slid_q <= 1'b1;
					end else begin
						filled_q <= filled_q + 11'd1;
						slid_q   <= 1'b0;
					end
					state_q <= S_PUSH_ADD;
				end
				S_PUSH_ADD: begin
					wv_q   <= sat_add64(wv_q, wr_data.value);
					wc_q   <= (wc_sum > 65'hFFFF_FFFF_FFFF) ? '1 : wc_sum[47:0];
					head_q <= (head_inc >= w_ext) ? '0 : head_q + AW'(1);
					new_q.frame_start_time <= first_q ? fb_q : gap_t_q;
					if (slid_q && !first_q) begin
						if (reported_q < 6'(MAX_GAP_RESULTS)) begin
							reported_q <= reported_q + 6'd1;
						end else begin
							trunc_q <= 1'b1;
						end
					end
					if (slid_q && (first_q || reported_q < 6'(MAX_GAP_RESULTS))) begin
						state_q <= S_MSTART;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_MSTART: begin
					new_q.window_trades <= wc_q;
					new_q.window_empty  <= (wc_q == '0);
					new_q.gap_truncated <= 1'b0;
					new_q.last          <= 1'b0;
					new_q.mean_value    <= '0;
					state_q <= (wc_q == '0) ? S_RESULT : S_MDIV;
				end
				S_MDIV: begin
					if (div_done) begin
						new_q.mean_value <= div_quo;
						state_q          <= S_RESULT;
					end
				end
				S_RESULT: begin
					// hold one result back until it is known whether it is the last
					if (!pend_v_q) begin
						pend_q   <= new_q;
						pend_v_q <= 1'b1;
						state_q  <= S_NEXT;
					end else if (out_free) begin
						out_q    <= pend_q;
						out_v_q  <= 1'b1;
						pend_q   <= new_q;
						state_q  <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (first_q) begin
						first_q <= 1'b0;
					end else begin
						j_q     <= j_inc;
						gap_t_q <= gap_t_q + {16'b0, hop_eff};
					end
					if (first_q ? (walk_q != '0) : (j_inc < walk_q)) begin
						state_q <= S_PUSH_RD;
					end else if (gaps_q > {36'b0, walk_q}) begin
						state_q <= S_ADV_DIV;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_ADV_DIV: begin
					// all-empty ring: the rest of the gap only rotates the head
					if (div_done) begin
						head_q  <= (head_adv >= w_ext) ? AW'(head_adv - w_ext)
							: AW'(head_adv);
						trunc_q <= 1'b1;
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					fb_q <= new_fb_q;
					fv_q <= value_q;
					fc_q <= 32'd1;
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q    <= fin_res;
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// input capture and product
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			ts_q    <= in_ch.timestamp;
			price_q <= in_ch.trade_price;
			vol_q   <= in_ch.trade_volume;
		end
		if (state_q == S_MUL) begin
			value_q <= {32'b0, price_q} * {32'b0, vol_q};
		end
	end

	assign in_ch.ready             = (state_q == S_IDLE);
	assign out_ch.valid            = out_v_q;
	assign out_ch.mean_value       = out_q.mean_value;
	assign out_ch.window_trades    = out_q.window_trades;
	assign out_ch.frame_start_time = out_q.frame_start_time;
	assign out_ch.window_empty     = out_q.window_empty;
	assign out_ch.gap_truncated    = out_q.gap_truncated;
	assign out_ch.last             = out_q.last;

endmodule

// File: src/fbsa_cfg.sv
module fbsa_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbsa_pkg::APB_AW-1:0]   paddr,
	input  logic [fbsa_pkg::APB_DW-1:0]   pwdata,
	output logic [fbsa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output fbsa_pkg::cfg_t                cfg
);

	logic [fbsa_pkg::HOP_W-1:0] hop_q;
	logic [fbsa_pkg::WF_W-1:0]  wf_q;
	logic                       win_wr_q;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// register writes; window size write also pulses a ring clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q    <= fbsa_pkg::HOP_RESET;
			wf_q     <= fbsa_pkg::WF_RESET;
			win_wr_q <= 1'b0;
		end else begin
			win_wr_q <= 1'b0;
			if (wr) begin
				case (paddr[2])
					fbsa_pkg::REG_HOP_MS: begin
						hop_q <= pwdata[fbsa_pkg::HOP_W-1:0];
					end
					fbsa_pkg::REG_WINDOW_FRAMES: begin
						wf_q     <= pwdata[fbsa_pkg::WF_W-1:0];
						win_wr_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[2])
			fbsa_pkg::REG_HOP_MS:        prdata = hop_q;
			fbsa_pkg::REG_WINDOW_FRAMES: prdata = {{(fbsa_pkg::APB_DW-fbsa_pkg::WF_W){1'b0}}, wf_q};
			default:                     prdata = '0;
		endcase
	end

	assign cfg.hop_ms        = hop_q;
	assign cfg.window_frames = wf_q;
	assign cfg.win_wr        = win_wr_q;

endmodule

// File: src/fbsa_ring.sv
module fbsa_ring #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output fbsa_pkg::ring_ent_t  rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  fbsa_pkg::ring_ent_t  wr_data
);

	fbsa_pkg::ring_ent_t mem_q [DEPTH];
	fbsa_pkg::ring_ent_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/fbsa_div.sv
module fbsa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [47:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [47:0] remainder
);

	// restoring divider, one quotient bit per cycle
	logic [63:0] quo_q;
	logic [47:0] rem_q;
	logic [47:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [48:0] sh;
	logic [48:0] diff;
	logic        ge;

	assign sh   = {rem_q, quo_q[63]};
	assign diff = sh - {1'b0, div_q};
	assign ge   = sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[47:0] : sh[47:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
